@@ src/b2da_pkg.sv @@
// Shared types and constants for the binary to decimal ASCII formatter.
package b2da_pkg;

  localparam int unsigned ValueBits     = 32;
  localparam int unsigned MaxDigits     = 9;
  localparam int unsigned CountBits     = 4;
  localparam int unsigned CharBits      = 7;
  localparam int unsigned BcdDigitBits  = 4;

  localparam logic [CharBits-1:0] CharSpace = 7'h20;
  localparam logic [CharBits-1:0] CharZero  = 7'h30;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [CountBits-1:0] digit_count;
  } in_beat_t;

  typedef struct packed {
    logic [CharBits-1:0] character;
    logic                last;
  } out_beat_t;

  // Conversion finished, with saturated field width.
  typedef struct packed {
    logic                 done;
    logic [CountBits-1:0] count;
  } cvt_t;

endpackage

@@ src/b2da_dabble.sv @@
// Bit-serial double dabble: one value bit shifted into the BCD register per cycle.
module b2da_dabble #(
  parameter int unsigned MAX_DIGITS = b2da_pkg::MaxDigits
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  b2da_pkg::in_beat_t                          beat_i,
  output b2da_pkg::cvt_t                              cvt_o,
  output logic [MAX_DIGITS-1:0][b2da_pkg::BcdDigitBits-1:0] bcd_o
);
  import b2da_pkg::*;

  localparam int unsigned CntW = $clog2(ValueBits + 1);

  logic                                     busy_q, busy_d;
  logic                                     done_q, done_d;
  logic [CntW-1:0]                          cnt_q, cnt_d;
  logic [ValueBits-1:0]                     val_q, val_d;
  logic [MAX_DIGITS-1:0][BcdDigitBits-1:0]  bcd_q, bcd_d;
  logic [MAX_DIGITS-1:0][BcdDigitBits-1:0]  adj;
  logic [MAX_DIGITS*BcdDigitBits:0]         shifted;
  logic [CountBits-1:0]                     count_q, count_d;

  always_comb begin
    for (int i = 0; i < int'(MAX_DIGITS); i++) begin
      adj[i] = (bcd_q[i] >= BcdDigitBits'(5)) ? bcd_q[i] + BcdDigitBits'(3) : bcd_q[i];
    end
  end

  assign shifted = {adj, val_q[ValueBits-1]};

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    val_d   = val_q;
    bcd_d   = bcd_q;
    count_d = count_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CntW'(ValueBits);
      val_d   = beat_i.value;
      bcd_d   = '0;
      count_d = (beat_i.digit_count > CountBits'(MAX_DIGITS)) ?
                CountBits'(MAX_DIGITS) : beat_i.digit_count;
    end else if (busy_q) begin
      // carry out of the top digit drops: result is value mod 10^MAX_DIGITS
      bcd_d = shifted[MAX_DIGITS*BcdDigitBits-1:0];
      val_d = {val_q[ValueBits-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    bcd_q   <= bcd_d;
    count_q <= count_d;
  end

  assign cvt_o.done  = done_q;
  assign cvt_o.count = count_q;
  assign bcd_o       = bcd_q;

endmodule

@@ src/b2da_emit.sv @@
// Character serializer: picks BCD digits most significant first, blanks leading zeros.
module b2da_emit #(
  parameter int unsigned MAX_DIGITS = b2da_pkg::MaxDigits
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  b2da_pkg::cvt_t                                    cvt_i,
  input  logic [MAX_DIGITS-1:0][b2da_pkg::BcdDigitBits-1:0] bcd_i,
  output logic                                              out_valid_o,
  input  logic                                              out_stall_i,
  output b2da_pkg::out_beat_t                               out_data_o,
  output logic                                              finish_o
);
  import b2da_pkg::*;

  localparam int unsigned IdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic                    active_q, active_d;
  logic                    lead_q, lead_d;
  logic [IdxW-1:0]         idx_q, idx_d;
  logic                    valid_q, valid_d;
  out_beat_t               data_q, data_d;
  logic [BcdDigitBits-1:0] digit;
  logic                    advance;
  logic                    blank;

  assign digit   = bcd_i[idx_q];
  assign advance = !valid_q || !out_stall_i;
  assign blank   = lead_q && (digit == '0) && (idx_q != '0);

  always_comb begin
    active_d = active_q;
    lead_d   = lead_q;
    idx_d    = idx_q;
    valid_d  = valid_q;
    data_d   = data_q;
    finish_o = 1'b0;
    if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
      if (data_q.last) begin
        finish_o = 1'b1;
      end
    end
    if (cvt_i.done) begin
      if (cvt_i.count == '0) begin
        finish_o = 1'b1;
      end else begin
        active_d = 1'b1;
        lead_d   = 1'b1;
        idx_d    = IdxW'(cvt_i.count - CountBits'(1));
      end
    end else if (active_q && advance) begin
      valid_d          = 1'b1;
      data_d.character = blank ? CharSpace : CharZero + CharBits'(digit);
      data_d.last      = (idx_q == '0);
      lead_d           = blank;
      idx_d            = idx_q - IdxW'(1);
      if (idx_q == '0) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lead_q <= lead_d;
    idx_q  <= idx_d;
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ src/binary_to_decimal_ascii.sv @@
// Binary to decimal ASCII formatter: top level.
// Prints value mod 10^digit_count as right-aligned ASCII, most significant first,
// leading zeros as spaces, final character flagged by last; widths above
// MAX_DIGITS saturate and a width of zero prints nothing. One item at a time:
// the bit-serial double dabble shifts in the value bit by bit, then one
// character per cycle leaves through the output register while out_stall_i is
// low. in_stall_o stays high from acceptance until the last character is
// taken, or for a width of zero until the conversion is done.
module binary_to_decimal_ascii #(
  parameter int unsigned MAX_DIGITS = b2da_pkg::MaxDigits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  b2da_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output b2da_pkg::out_beat_t out_data_o
);
  import b2da_pkg::*;

  logic                                    busy_q, busy_d;
  logic                                    start;
  logic                                    finish;
  cvt_t                                    cvt;
  logic [MAX_DIGITS-1:0][BcdDigitBits-1:0] bcd;

  assign start      = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;

  always_comb begin
    busy_d = busy_q;
    if (start) begin
      busy_d = 1'b1;
    end else if (finish) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  b2da_dabble #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .beat_i (in_data_i),
    .cvt_o  (cvt),
    .bcd_o  (bcd)
  );

  b2da_emit #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cvt_i      (cvt),
    .bcd_i      (bcd),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .finish_o   (finish)
  );

  a_out_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("output beat while idle");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("accept did not block input");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last) |=> (!out_valid_o && !in_stall_o))
    else $error("beat after last character");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.character == CharSpace ||
                     (out_data_o.character >= CharZero &&
                      out_data_o.character <= CharZero + CharBits'(9))))
    else $error("bad character");

endmodule
